/* rtl/core/transposed_conv3d_scatter_assert.svh */
// assertion macros for the transposed convolution block
`ifndef TRANSPOSED_CONV3D_SCATTER_ASSERT_SVH
`define TRANSPOSED_CONV3D_SCATTER_ASSERT_SVH

`ifndef SYNTH
`define TCS_ASSERT_HOLD(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tcs check failed");
`define TCS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tcs check failed");
`else
`define TCS_ASSERT_HOLD(label, cond)
`define TCS_ASSERT_NEXT(label, pre, post)
`endif

`endif

/* rtl/core/tcs_pkg.sv */
package tcs_pkg;

    // default sizes
    localparam int DEF_OUT_CHANNELS    = 8;
    localparam int DEF_MAX_IN_CHANNELS = 16;
    localparam int DEF_MAX_KERNEL      = 4;
    localparam int DEF_MAX_OUT_DIM     = 16;

    // datapath widths
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 32;
    localparam int ACC_W    = 40;

    // request modes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_IN_CHANNELS   = 3'd0;
    localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd1;
    localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd2;
    localparam logic [2:0] REG_KERNEL_DEPTH  = 3'd3;
    localparam logic [2:0] REG_STRIDE        = 3'd4;
    localparam logic [2:0] REG_OUT_WIDTH     = 3'd5;
    localparam logic [2:0] REG_OUT_HEIGHT    = 3'd6;
    localparam logic [2:0] REG_OUT_DEPTH     = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAT,
        S_DRAIN,
        S_READ
    } state_t;

    function automatic int clamp_int(input int v, input int lo, input int hi);
        int r;
        r = v;
        if (r < lo)
        begin
            r = lo;
        end
        if (r > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

/* rtl/core/transposed_conv3d_scatter.sv */
// mode 0 (load weight) and samples that are dropped leave busy low
// mode 1 keeps busy high while it scatters all kernel_width*kernel_height*kernel_depth
//   offsets, one per cycle, through a read, multiply, accumulate, write-back pipe
// mode 2 steps to the read state, then registers its result with result_valid;
//   results are never stalled by the receiver
// mode 3 and reset sweep all MAX_OUT_DIM**3 rows of the output memory, one row per cycle
// (4096 rows at the defaults) with busy high; registers reset to 1, weights are undefined
`include "transposed_conv3d_scatter_assert.svh"

module transposed_conv3d_scatter #(
    parameter int OUT_CHANNELS    = tcs_pkg::DEF_OUT_CHANNELS,
    parameter int MAX_IN_CHANNELS = tcs_pkg::DEF_MAX_IN_CHANNELS,
    parameter int MAX_KERNEL      = tcs_pkg::DEF_MAX_KERNEL,
    parameter int MAX_OUT_DIM     = tcs_pkg::DEF_MAX_OUT_DIM
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [3:0]  in_channel,
    input  logic [2:0]  out_channel,
    input  logic [3:0]  pos_x,
    input  logic [3:0]  pos_y,
    input  logic [3:0]  pos_z,
    input  logic signed [15:0] sample,
    output logic        result_valid,
    output logic signed [39:0] out_value,
    output logic        in_range,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW     = tcs_pkg::SAMPLE_W;
    localparam int AC     = tcs_pkg::ACC_W;
    localparam int KC_W   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int WDEPTH = MAX_KERNEL * MAX_KERNEL * MAX_KERNEL * MAX_IN_CHANNELS;
    localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int ODEPTH = MAX_OUT_DIM * MAX_OUT_DIM * MAX_OUT_DIM;
    localparam int OA_W   = $clog2(ODEPTH);

    // configuration registers
    logic [4:0] in_channels_reg, out_width_reg, out_height_reg, out_depth_reg;
    logic [2:0] kernel_width_reg, kernel_height_reg, kernel_depth_reg, stride_reg;

    // control state
    tcs_pkg::state_t state_reg, state_next;
    logic [KC_W-1:0] kx_reg, ky_reg, kz_reg;
    logic [KC_W-1:0] kx_next, ky_next, kz_next;
    logic [OA_W-1:0] clr_reg, clr_next;
    logic            v1_reg;
    logic [OA_W-1:0] a1_reg;

    // request payload held for the scatter
    logic [3:0]             ic_reg;
    logic [7:0]             bx_reg, by_reg, bz_reg;
    logic signed [SW-1:0]   s_reg;
    logic [2:0]             rd_oc_reg;
    logic                   rd_ok_reg;

    // result registers
    logic                   result_valid_reg;
    logic signed [AC-1:0]   out_value_reg;
    logic                   in_range_reg;

    // clamped settings
    int nic, kw, kh, kd, st, ow, oh, od;
    logic accept, scat_ok, rd_ok, load_ok, issue, last_off, cfg_wr;

    // memory ports
    logic [OUT_CHANNELS-1:0]    w_we;
    logic [WA_W-1:0]            w_waddr, w_raddr;
    logic [OUT_CHANNELS*SW-1:0] w_wdata, w_rdata;
    logic [OUT_CHANNELS-1:0]    o_we;
    logic [OA_W-1:0]            o_waddr, o_raddr, scat_oaddr;
    logic [OUT_CHANNELS*AC-1:0] o_wdata, o_rdata;
    logic                       o_re;
    logic                       mac_we;
    logic [OA_W-1:0]            mac_waddr;
    logic [OUT_CHANNELS*AC-1:0] mac_wdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign accept = start && !busy;
    assign busy   = (state_reg != tcs_pkg::S_IDLE);

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_channels_reg   <= 5'd1;
            kernel_width_reg  <= 3'd1;
            kernel_height_reg <= 3'd1;
            kernel_depth_reg  <= 3'd1;
            stride_reg        <= 3'd1;
            out_width_reg     <= 5'd1;
            out_height_reg    <= 5'd1;
            out_depth_reg     <= 5'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                tcs_pkg::REG_IN_CHANNELS:   in_channels_reg   <= pwdata[4:0];
                tcs_pkg::REG_KERNEL_WIDTH:  kernel_width_reg  <= pwdata[2:0];
                tcs_pkg::REG_KERNEL_HEIGHT: kernel_height_reg <= pwdata[2:0];
                tcs_pkg::REG_KERNEL_DEPTH:  kernel_depth_reg  <= pwdata[2:0];
                tcs_pkg::REG_STRIDE:        stride_reg        <= pwdata[2:0];
                tcs_pkg::REG_OUT_WIDTH:     out_width_reg     <= pwdata[4:0];
                tcs_pkg::REG_OUT_HEIGHT:    out_height_reg    <= pwdata[4:0];
                tcs_pkg::REG_OUT_DEPTH:     out_depth_reg     <= pwdata[4:0];
                default:                    in_channels_reg   <= in_channels_reg;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (paddr[4:2])
            tcs_pkg::REG_IN_CHANNELS:   prdata = {27'd0, in_channels_reg};
            tcs_pkg::REG_KERNEL_WIDTH:  prdata = {29'd0, kernel_width_reg};
            tcs_pkg::REG_KERNEL_HEIGHT: prdata = {29'd0, kernel_height_reg};
            tcs_pkg::REG_KERNEL_DEPTH:  prdata = {29'd0, kernel_depth_reg};
            tcs_pkg::REG_STRIDE:        prdata = {29'd0, stride_reg};
            tcs_pkg::REG_OUT_WIDTH:     prdata = {27'd0, out_width_reg};
            tcs_pkg::REG_OUT_HEIGHT:    prdata = {27'd0, out_height_reg};
            tcs_pkg::REG_OUT_DEPTH:     prdata = {27'd0, out_depth_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // clamped settings and request checks
    always_comb
    begin
        nic = tcs_pkg::clamp_int(int'(in_channels_reg), 1, MAX_IN_CHANNELS);
        kw  = tcs_pkg::clamp_int(int'(kernel_width_reg), 1, MAX_KERNEL);
        kh  = tcs_pkg::clamp_int(int'(kernel_height_reg), 1, MAX_KERNEL);
        kd  = tcs_pkg::clamp_int(int'(kernel_depth_reg), 1, MAX_KERNEL);
        st  = tcs_pkg::clamp_int(int'(stride_reg), 1, 7);
        ow  = tcs_pkg::clamp_int(int'(out_width_reg), 1, MAX_OUT_DIM);
        oh  = tcs_pkg::clamp_int(int'(out_height_reg), 1, MAX_OUT_DIM);
        od  = tcs_pkg::clamp_int(int'(out_depth_reg), 1, MAX_OUT_DIM);
        scat_ok = (int'(in_channel) < nic)
               && (int'(pos_x) * st + kw <= ow)
               && (int'(pos_y) * st + kh <= oh)
               && (int'(pos_z) * st + kd <= od);
        rd_ok   = (int'(pos_x) < ow) && (int'(pos_y) < oh) && (int'(pos_z) < od)
               && (int'(out_channel) < OUT_CHANNELS);
        load_ok = (int'(pos_x) < MAX_KERNEL) && (int'(pos_y) < MAX_KERNEL)
               && (int'(pos_z) < MAX_KERNEL) && (int'(in_channel) < MAX_IN_CHANNELS)
               && (int'(out_channel) < OUT_CHANNELS);
    end

    // weight memory write on load requests
    always_comb
    begin
        w_waddr = WA_W'(((int'(pos_z) * MAX_KERNEL + int'(pos_y)) * MAX_KERNEL
                  + int'(pos_x)) * MAX_IN_CHANNELS + int'(in_channel));
        for (int l = 0; l < OUT_CHANNELS; l++)
        begin
            w_we[l] = accept && (mode == tcs_pkg::MODE_LOAD) && load_ok
                   && (int'(out_channel) == l);
            w_wdata[l*SW +: SW] = sample;
        end
    end

    // addresses for the current kernel offset
    assign w_raddr = WA_W'(((int'(kz_reg) * MAX_KERNEL + int'(ky_reg)) * MAX_KERNEL
                     + int'(kx_reg)) * MAX_IN_CHANNELS + int'(ic_reg));
    assign scat_oaddr = OA_W'(((int'(bz_reg) + int'(kz_reg)) * MAX_OUT_DIM
                        + int'(by_reg) + int'(ky_reg)) * MAX_OUT_DIM
                        + int'(bx_reg) + int'(kx_reg));

    assign issue    = (state_reg == tcs_pkg::S_SCAT);
    assign last_off = (int'(kx_reg) == kw - 1) && (int'(ky_reg) == kh - 1)
                   && (int'(kz_reg) == kd - 1);

    // output memory port selection
    always_comb
    begin
        o_re    = issue || (accept && (mode == tcs_pkg::MODE_READ));
        o_raddr = issue ? scat_oaddr
                        : OA_W'((int'(pos_z) * MAX_OUT_DIM + int'(pos_y)) * MAX_OUT_DIM
                          + int'(pos_x));
        if (state_reg == tcs_pkg::S_CLEAR)
        begin
            o_we    = '1;
            o_waddr = clr_reg;
            o_wdata = '0;
        end
        else
        begin
            o_we    = {OUT_CHANNELS{mac_we}};
            o_waddr = mac_waddr;
            o_wdata = mac_wdata;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        kx_next    = kx_reg;
        ky_next    = ky_reg;
        kz_next    = kz_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            tcs_pkg::S_IDLE:
            begin
                kx_next = '0;
                ky_next = '0;
                kz_next = '0;
                clr_next = '0;
                if (accept)
                begin
                    unique case (mode)
                        tcs_pkg::MODE_SAMPLE:
                        begin
                            if (scat_ok)
                            begin
                                state_next = tcs_pkg::S_SCAT;
                            end
                        end
                        tcs_pkg::MODE_READ:  state_next = tcs_pkg::S_READ;
                        tcs_pkg::MODE_CLEAR: state_next = tcs_pkg::S_CLEAR;
                        default:             state_next = tcs_pkg::S_IDLE;
                    endcase
                end
            end
            tcs_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (int'(clr_reg) == ODEPTH - 1)
                begin
                    state_next = tcs_pkg::S_IDLE;
                end
            end
            tcs_pkg::S_SCAT:
            begin
                if (last_off)
                begin
                    state_next = tcs_pkg::S_DRAIN;
                end
                else if (int'(kx_reg) != kw - 1)
                begin
                    kx_next = kx_reg + 1'b1;
                end
                else if (int'(ky_reg) != kh - 1)
                begin
                    kx_next = '0;
                    ky_next = ky_reg + 1'b1;
                end
                else
                begin
                    kx_next = '0;
                    ky_next = '0;
                    kz_next = kz_reg + 1'b1;
                end
            end
            tcs_pkg::S_DRAIN:
            begin
                if (!v1_reg && !mac_we)
                begin
                    state_next = tcs_pkg::S_IDLE;
                end
            end
            tcs_pkg::S_READ: state_next = tcs_pkg::S_IDLE;
            default:         state_next = tcs_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tcs_pkg::S_CLEAR;
            kx_reg           <= '0;
            ky_reg           <= '0;
            kz_reg           <= '0;
            clr_reg          <= '0;
            v1_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            kx_reg           <= kx_next;
            ky_reg           <= ky_next;
            kz_reg           <= kz_next;
            clr_reg          <= clr_next;
            v1_reg           <= issue;
            result_valid_reg <= (state_reg == tcs_pkg::S_READ);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a1_reg <= scat_oaddr;
        if (accept)
        begin
            ic_reg    <= in_channel;
            bx_reg    <= 8'(int'(pos_x) * st);
            by_reg    <= 8'(int'(pos_y) * st);
            bz_reg    <= 8'(int'(pos_z) * st);
            s_reg     <= sample;
            rd_oc_reg <= out_channel;
            rd_ok_reg <= rd_ok;
        end
        if (state_reg == tcs_pkg::S_READ)
        begin
            in_range_reg  <= rd_ok_reg;
            out_value_reg <= rd_ok_reg ? o_rdata[int'(rd_oc_reg)*AC +: AC] : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_value    = out_value_reg;
    assign in_range     = in_range_reg;

    tcs_ram #(
        .LANES  (OUT_CHANNELS),
        .LANE_W (SW),
        .DEPTH  (WDEPTH),
        .AW     (WA_W)
    ) u_wmem (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .re    (issue),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    tcs_ram #(
        .LANES  (OUT_CHANNELS),
        .LANE_W (AC),
        .DEPTH  (ODEPTH),
        .AW     (OA_W)
    ) u_omem (
        .clk   (clk),
        .we    (o_we),
        .waddr (o_waddr),
        .wdata (o_wdata),
        .re    (o_re),
        .raddr (o_raddr),
        .rdata (o_rdata)
    );

    tcs_mac #(
        .LANES (OUT_CHANNELS),
        .AW    (OA_W)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v1_reg),
        .in_addr  (a1_reg),
        .sample   (s_reg),
        .w_row    (w_rdata),
        .acc_row  (o_rdata),
        .wr_en    (mac_we),
        .wr_addr  (mac_waddr),
        .wr_data  (mac_wdata)
    );

    // checks
    `TCS_ASSERT_HOLD(a_no_wb_in_clear, !(mac_we && state_reg == tcs_pkg::S_CLEAR))
    `TCS_ASSERT_HOLD(a_idle_drained, !(state_reg == tcs_pkg::S_IDLE && (v1_reg || mac_we)))
    `TCS_ASSERT_NEXT(a_read_then_result, state_reg == tcs_pkg::S_READ, result_valid)
    `TCS_ASSERT_NEXT(a_result_from_read, !(state_reg == tcs_pkg::S_READ), !result_valid)
    `TCS_ASSERT_NEXT(a_scat_issues, state_reg == tcs_pkg::S_SCAT, v1_reg)

endmodule

/* rtl/core/tcs_ram.sv */
module tcs_ram #(
    parameter int LANES  = tcs_pkg::DEF_OUT_CHANNELS,
    parameter int LANE_W = tcs_pkg::SAMPLE_W,
    parameter int DEPTH  = 1024,
    parameter int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    clk,
    input  logic [LANES-1:0]        we,
    input  logic [AW-1:0]           waddr,
    input  logic [LANES*LANE_W-1:0] wdata,
    input  logic                    re,
    input  logic [AW-1:0]           raddr,
    output logic [LANES*LANE_W-1:0] rdata
);

    logic [LANES*LANE_W-1:0] mem [DEPTH];
    logic [LANES*LANE_W-1:0] rdata_reg;

    // lane-masked write
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (we[l])
            begin
                mem[waddr][l*LANE_W +: LANE_W] <= wdata[l*LANE_W +: LANE_W];
            end
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/tcs_mac.sv */
module tcs_mac #(
    parameter int LANES = tcs_pkg::DEF_OUT_CHANNELS,
    parameter int AW    = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [AW-1:0]                     in_addr,
    input  logic signed [tcs_pkg::SAMPLE_W-1:0] sample,
    input  logic [LANES*tcs_pkg::SAMPLE_W-1:0] w_row,
    input  logic [LANES*tcs_pkg::ACC_W-1:0]    acc_row,
    output logic                              wr_en,
    output logic [AW-1:0]                     wr_addr,
    output logic [LANES*tcs_pkg::ACC_W-1:0]    wr_data
);

    localparam int SW = tcs_pkg::SAMPLE_W;
    localparam int PW = tcs_pkg::PROD_W;
    localparam int AC = tcs_pkg::ACC_W;

    logic signed [PW-1:0] prod_reg [LANES];
    logic [LANES*AC-1:0]  acc_reg;
    logic [AW-1:0]        addr_reg;
    logic                 valid_reg;

    // product stage, one multiplier per lane
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            prod_reg[l] <= PW'(sample * $signed(w_row[l*SW +: SW]));
        end
        acc_reg  <= acc_row;
        addr_reg <= in_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // saturating accumulate
    always_comb
    begin
        logic signed [AC:0] sum;
        for (int l = 0; l < LANES; l++)
        begin
            sum = $signed({acc_reg[l*AC + AC - 1], acc_reg[l*AC +: AC]})
                + (AC + 1)'(prod_reg[l]);
            if (sum[AC] != sum[AC-1])
            begin
                wr_data[l*AC +: AC] = sum[AC] ? {1'b1, {(AC-1){1'b0}}}
                                              : {1'b0, {(AC-1){1'b1}}};
            end
            else
            begin
                wr_data[l*AC +: AC] = sum[AC-1:0];
            end
        end
    end

    assign wr_en   = valid_reg;
    assign wr_addr = addr_reg;

endmodule

/* dv/transposed_conv3d_scatter_checker.sv */
module transposed_conv3d_scatter_checker
    import tcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         mode,
    input  logic [3:0]         in_channel,
    input  logic [2:0]         out_channel,
    input  logic [3:0]         pos_x,
    input  logic [3:0]         pos_y,
    input  logic [3:0]         pos_z,
    input  logic signed [15:0] sample,
    input  logic               result_valid,
    input  logic signed [39:0] out_value,
    input  logic               in_range,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output int                 fail_count,
    output int                 reads_pending,
    output int                 reads_checked
);

    localparam int NOC  = DEF_OUT_CHANNELS;
    localparam int NIC  = DEF_MAX_IN_CHANNELS;
    localparam int NK   = DEF_MAX_KERNEL;
    localparam int NDIM = DEF_MAX_OUT_DIM;
    localparam longint ACC_HI = 64'sd549755813887;
    localparam longint ACC_LO = -64'sd549755813888;

    typedef struct packed {
        logic signed [39:0] value;
        logic               hit;
    } readback_t;

    logic signed [15:0] kernel_mem [NK*NK*NK*NIC*NOC];
    logic signed [39:0] acc_mem [NDIM*NDIM*NDIM*NOC];
    logic [4:0]         regs [8];
    readback_t          readback_q [$];

    function automatic int bound(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int kernel_slot(input int kx, input int ky, input int kz,
                                       input int ic, input int oc);
        return (((kz * NK + ky) * NK + kx) * NIC + ic) * NOC + oc;
    endfunction

    function automatic int acc_slot(input int ox, input int oy, input int oz, input int oc);
        return ((oz * NDIM + oy) * NDIM + ox) * NOC + oc;
    endfunction

    // scatter one input sample into every output channel and kernel offset
    task automatic scatter_sample(input int ic, input int x, input int y, input int z,
                                  input logic signed [15:0] s);
        int nic, kw, kh, kd, st, ow, oh, od, bx, by, bz, idx;
        longint sum;
        nic = bound(regs[REG_IN_CHANNELS], 1, NIC);
        kw  = bound(regs[REG_KERNEL_WIDTH], 1, NK);
        kh  = bound(regs[REG_KERNEL_HEIGHT], 1, NK);
        kd  = bound(regs[REG_KERNEL_DEPTH], 1, NK);
        st  = bound(regs[REG_STRIDE], 1, 7);
        ow  = bound(regs[REG_OUT_WIDTH], 1, NDIM);
        oh  = bound(regs[REG_OUT_HEIGHT], 1, NDIM);
        od  = bound(regs[REG_OUT_DEPTH], 1, NDIM);
        bx  = x * st;
        by  = y * st;
        bz  = z * st;
        if (ic >= nic || bx + kw > ow || by + kh > oh || bz + kd > od)
        begin
            return;
        end
        for (int oc = 0; oc < NOC; oc++)
        begin
            for (int kz = 0; kz < kd; kz++)
            begin
                for (int ky = 0; ky < kh; ky++)
                begin
                    for (int kx = 0; kx < kw; kx++)
                    begin
                        idx = acc_slot(bx + kx, by + ky, bz + kz, oc);
                        sum = longint'(acc_mem[idx])
                            + longint'(s) * longint'(kernel_mem[kernel_slot(kx, ky, kz, ic, oc)]);
                        if (sum > ACC_HI)
                        begin
                            sum = ACC_HI;
                        end
                        if (sum < ACC_LO)
                        begin
                            sum = ACC_LO;
                        end
                        acc_mem[idx] = sum[39:0];
                    end
                end
            end
        end
    endtask

    // expected readback of one accumulator
    function automatic readback_t read_acc(input int oc, input int x, input int y, input int z);
        readback_t r;
        int ow, oh, od;
        ow = bound(regs[REG_OUT_WIDTH], 1, NDIM);
        oh = bound(regs[REG_OUT_HEIGHT], 1, NDIM);
        od = bound(regs[REG_OUT_DEPTH], 1, NDIM);
        r.hit   = (x < ow && y < oh && z < od && oc < NOC);
        r.value = r.hit ? acc_mem[acc_slot(x, y, z, oc)] : '0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        readback_t want;
        if (!rst_n)
        begin
            foreach (regs[i])
            begin
                regs[i] = 5'd1;
            end
            foreach (acc_mem[i])
            begin
                acc_mem[i] = '0;
            end
            foreach (kernel_mem[i])
            begin
                kernel_mem[i] = '0;
            end
            readback_q.delete();
            fail_count    = 0;
            reads_checked = 0;
            reads_pending = 0;
        end
        else
        begin
            // compare a returned accumulator with the oldest read
            if (result_valid)
            begin
                if (readback_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("mismatch: result with no read pending, value %0d in_range %0b",
                                 out_value, in_range);
                    end
                end
                else
                begin
                    want = readback_q.pop_front();
                    reads_checked++;
                    if (want.value !== out_value || want.hit !== in_range)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("mismatch: out_value exp %0d got %0d, in_range exp %0b got %0b",
                                     want.value, out_value, want.hit, in_range);
                        end
                    end
                end
            end

            // register writes
            if (psel && penable && pwrite && pready && paddr[4:2] <= REG_OUT_DEPTH)
            begin
                regs[paddr[4:2]] = (paddr[4:2] >= REG_KERNEL_WIDTH && paddr[4:2] <= REG_STRIDE)
                                 ? {2'b00, pwdata[2:0]} : pwdata[4:0];
            end

            // accepted request
            if (start && !busy)
            begin
                case (mode)
                    MODE_LOAD:
                    begin
                        if (pos_x < NK && pos_y < NK && pos_z < NK)
                        begin
                            kernel_mem[kernel_slot(pos_x, pos_y, pos_z, in_channel, out_channel)] = sample;
                        end
                    end
                    MODE_SAMPLE:
                    begin
                        scatter_sample(in_channel, pos_x, pos_y, pos_z, sample);
                    end
                    MODE_READ:
                    begin
                        readback_q.push_back(read_acc(out_channel, pos_x, pos_y, pos_z));
                    end
                    default:
                    begin
                        foreach (acc_mem[i])
                        begin
                            acc_mem[i] = '0;
                        end
                    end
                endcase
            end
            reads_pending = readback_q.size();
        end
    end

endmodule

/* dv/tb_transposed_conv3d_scatter.sv */
module tb_transposed_conv3d_scatter;
    import tcs_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int NK   = DEF_MAX_KERNEL;
    localparam int NIC  = DEF_MAX_IN_CHANNELS;
    localparam int NOC  = DEF_OUT_CHANNELS;
    localparam int NDIM = DEF_MAX_OUT_DIM;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         mode;
    logic [3:0]         in_channel;
    logic [2:0]         out_channel;
    logic [3:0]         pos_x;
    logic [3:0]         pos_y;
    logic [3:0]         pos_z;
    logic signed [15:0] sample;
    logic               result_valid;
    logic signed [39:0] out_value;
    logic               in_range;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int  fail_count;
    int  reads_pending;
    int  reads_checked;
    int  cycle_count;
    int  idle_pct;
    int  samples_sent;
    int  loads_sent;
    int  clears_sent;
    int  regs_tb [8];
    bit  kernel_loaded [NK*NK*NK*NIC*NOC];

    transposed_conv3d_scatter DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .in_channel(in_channel), .out_channel(out_channel),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .sample(sample),
        .result_valid(result_valid), .out_value(out_value), .in_range(in_range),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    transposed_conv3d_scatter_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .in_channel(in_channel), .out_channel(out_channel),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .sample(sample),
        .result_valid(result_valid), .out_value(out_value), .in_range(in_range),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count),
        .reads_pending(reads_pending), .reads_checked(reads_checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int bound(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int kernel_slot(input int kx, input int ky, input int kz,
                                       input int ic, input int oc);
        return (((kz * NK + ky) * NK + kx) * NIC + ic) * NOC + oc;
    endfunction

    // issue one request and hold it until taken
    task automatic issue(input logic [1:0] m, input int ic, input int oc, input int x,
                         input int y, input int z, input logic [15:0] s);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        mode        <= m;
        in_channel  <= ic[3:0];
        out_channel <= oc[2:0];
        pos_x       <= x[3:0];
        pos_y       <= y[3:0];
        pos_z       <= z[3:0];
        sample      <= s;
        start       <= 1'b1;
        do @(posedge clk); while (busy);
        if (m == MODE_LOAD)
        begin
            loads_sent++;
            if (x < NK && y < NK && z < NK)
            begin
                kernel_loaded[kernel_slot(x, y, z, ic, oc)] = 1'b1;
            end
        end
        else if (m == MODE_SAMPLE)
        begin
            samples_sent++;
        end
        else if (m == MODE_CLEAR)
        begin
            clears_sent++;
        end
    endtask

    // wait until the block is idle and every read has returned
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (busy || reads_pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        regs_tb[idx] = (idx >= REG_KERNEL_WIDTH && idx <= REG_STRIDE) ? (value & 7) : (value & 31);
    endtask

    task automatic set_regs(input int nic, input int kw, input int kh, input int kd,
                            input int st, input int ow, input int oh, input int od);
        settle();
        reg_write(REG_IN_CHANNELS, nic);
        reg_write(REG_KERNEL_WIDTH, kw);
        reg_write(REG_KERNEL_HEIGHT, kh);
        reg_write(REG_KERNEL_DEPTH, kd);
        reg_write(REG_STRIDE, st);
        reg_write(REG_OUT_WIDTH, ow);
        reg_write(REG_OUT_HEIGHT, oh);
        reg_write(REG_OUT_DEPTH, od);
        @(posedge clk);
    endtask

    // sample request; weights it would use are loaded first
    task automatic send_sample(input int ic, input int x, input int y, input int z,
                               input logic [15:0] s);
        int kw, kh, kd, st;
        kw = bound(regs_tb[REG_KERNEL_WIDTH], 1, NK);
        kh = bound(regs_tb[REG_KERNEL_HEIGHT], 1, NK);
        kd = bound(regs_tb[REG_KERNEL_DEPTH], 1, NK);
        st = bound(regs_tb[REG_STRIDE], 1, 7);
        if (ic < bound(regs_tb[REG_IN_CHANNELS], 1, NIC)
            && x * st + kw <= bound(regs_tb[REG_OUT_WIDTH], 1, NDIM)
            && y * st + kh <= bound(regs_tb[REG_OUT_HEIGHT], 1, NDIM)
            && z * st + kd <= bound(regs_tb[REG_OUT_DEPTH], 1, NDIM))
        begin
            for (int oc = 0; oc < NOC; oc++)
            begin
                for (int kz = 0; kz < kd; kz++)
                begin
                    for (int ky = 0; ky < kh; ky++)
                    begin
                        for (int kx = 0; kx < kw; kx++)
                        begin
                            if (!kernel_loaded[kernel_slot(kx, ky, kz, ic, oc)])
                            begin
                                issue(MODE_LOAD, ic, oc, kx, ky, kz, 16'($urandom()));
                            end
                        end
                    end
                end
            end
        end
        issue(MODE_SAMPLE, ic, $urandom_range(7), x, y, z, s);
    endtask

    // one random request shaped by the current register set
    task automatic random_request();
        int r, nic, kw, kh, kd, st, ow, oh, od;
        r   = $urandom_range(99);
        nic = bound(regs_tb[REG_IN_CHANNELS], 1, NIC);
        kw  = bound(regs_tb[REG_KERNEL_WIDTH], 1, NK);
        kh  = bound(regs_tb[REG_KERNEL_HEIGHT], 1, NK);
        kd  = bound(regs_tb[REG_KERNEL_DEPTH], 1, NK);
        st  = bound(regs_tb[REG_STRIDE], 1, 7);
        ow  = bound(regs_tb[REG_OUT_WIDTH], 1, NDIM);
        oh  = bound(regs_tb[REG_OUT_HEIGHT], 1, NDIM);
        od  = bound(regs_tb[REG_OUT_DEPTH], 1, NDIM);
        if (r < 12)
        begin
            if ($urandom_range(3) == 0)
            begin
                issue(MODE_LOAD, $urandom_range(15), $urandom_range(7), $urandom_range(15),
                      $urandom_range(15), $urandom_range(15), 16'($urandom()));
            end
            else
            begin
                issue(MODE_LOAD, $urandom_range(bound(nic, 1, 4) - 1), $urandom_range(7),
                      $urandom_range(kw - 1), $urandom_range(kh - 1), $urandom_range(kd - 1),
                      16'($urandom()));
            end
        end
        else if (r < 68)
        begin
            if ($urandom_range(4) == 0)
            begin
                send_sample($urandom_range(15), $urandom_range(15), $urandom_range(15),
                            $urandom_range(15), 16'($urandom()));
            end
            else
            begin
                send_sample($urandom_range(bound(nic, 1, 2) - 1),
                            $urandom_range(ow >= kw ? (ow - kw) / st : 0),
                            $urandom_range(oh >= kh ? (oh - kh) / st : 0),
                            $urandom_range(od >= kd ? (od - kd) / st : 0), 16'($urandom()));
            end
        end
        else if (r < 99)
        begin
            if ($urandom_range(4) == 0)
            begin
                issue(MODE_READ, $urandom_range(15), $urandom_range(7), $urandom_range(15),
                      $urandom_range(15), $urandom_range(15), 16'($urandom()));
            end
            else
            begin
                issue(MODE_READ, $urandom_range(15), $urandom_range(7), $urandom_range(ow - 1),
                      $urandom_range(oh - 1), $urandom_range(od - 1), 16'($urandom()));
            end
        end
        else
        begin
            issue(MODE_CLEAR, 0, 0, 0, 0, 0, 16'h0000);
        end
    endtask

    initial
    begin
        int phase_regs [7][8];
        int idle_plan [7];
        cycle_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        mode        = MODE_LOAD;
        in_channel  = '0;
        out_channel = '0;
        pos_x       = '0;
        pos_y       = '0;
        pos_z       = '0;
        sample      = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        idle_pct    = 0;
        samples_sent = 0;
        loads_sent  = 0;
        clears_sent = 0;
        foreach (regs_tb[i])
        begin
            regs_tb[i] = 1;
        end
        phase_regs = '{'{2, 2, 2, 1, 1, 8, 8, 8}, '{16, 1, 1, 1, 2, 16, 16, 16},
                       '{2, 3, 2, 1, 3, 16, 16, 16}, '{0, 0, 0, 0, 0, 0, 0, 0},
                       '{31, 7, 1, 0, 7, 31, 31, 31}, '{5, 3, 2, 1, 3, 12, 9, 5},
                       '{4, 2, 3, 1, 5, 3, 16, 2}};
        idle_plan  = '{0, 55, 55, 29, 0, 55, 29};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // reset sweep of the output memory
        repeat (2) @(posedge clk);
        settle();

        // directed: default registers, one voxel map
        for (int oc = 0; oc < NOC; oc++)
        begin
            issue(MODE_LOAD, 0, oc, 0, 0, 0, (oc % 2) ? 16'h8000 : 16'h7fff);
        end
        issue(MODE_LOAD, 0, 0, 4, 0, 0, 16'h1234);       // kernel x out of range
        issue(MODE_LOAD, 15, 7, 15, 15, 15, 16'hffff);   // all coordinates out of range
        send_sample(0, 0, 0, 0, 16'h8000);
        send_sample(0, 0, 0, 0, 16'h7fff);
        issue(MODE_SAMPLE, 15, 0, 0, 0, 0, 16'h0100);    // channel not in use
        issue(MODE_SAMPLE, 0, 0, 1, 0, 0, 16'h0100);     // footprint leaves the map
        issue(MODE_SAMPLE, 0, 0, 15, 15, 15, 16'h0100);
        issue(MODE_READ, 0, 0, 0, 0, 0, 16'h0000);
        issue(MODE_READ, 0, 7, 0, 0, 0, 16'h0000);
        issue(MODE_READ, 0, 1, 1, 0, 0, 16'h0000);       // read outside the map
        issue(MODE_READ, 15, 3, 15, 15, 15, 16'hffff);
        issue(MODE_CLEAR, 0, 0, 0, 0, 0, 16'h0000);
        issue(MODE_READ, 0, 0, 0, 0, 0, 16'h0000);

        // random phases over several register sets
        for (int p = 0; p < 7; p++)
        begin
            set_regs(phase_regs[p][0], phase_regs[p][1], phase_regs[p][2], phase_regs[p][3],
                     phase_regs[p][4], phase_regs[p][5], phase_regs[p][6], phase_regs[p][7]);
            if (p % 2 == 1)
            begin
                issue(MODE_CLEAR, 0, 0, 0, 0, 0, 16'h0000);
            end
            idle_pct = idle_plan[p];
            for (int n = 0; n < 50; n++)
            begin
                random_request();
                // hold off until all reads are back
                if (n == 25)
                begin
                    settle();
                end
            end
        end
        settle();

        $display("sent %0d samples, %0d weight loads, %0d clears; %0d reads checked",
                 samples_sent, loads_sent, clears_sent, reads_checked);
        $display("covered extreme products, dropped samples, out-of-map reads and clamped registers");
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
